// ----- src/whc_pkg.sv -----
// ----------------------------------------------------------------------------
// whc_pkg
// Shared types, constants and the microcode table for the weighted
// complete-intersection Hilbert function unit.
// ----------------------------------------------------------------------------
package whc_pkg;

  localparam int MAX_ARG    = 1275;
  localparam int TBL_DEPTH  = MAX_ARG + 1;
  localparam int ADDR_W     = $clog2(TBL_DEPTH);
  localparam int CNT_W      = 32;
  localparam int N_W        = 11;
  localparam int ARG_W      = 13;
  localparam int W_W        = 6;
  localparam int D_W        = 8;
  localparam int NUM_W      = 4;
  localparam int WSEL_W     = 2;
  localparam int K_W        = 3;
  localparam int WSUM_W     = 9;
  localparam int KD_W       = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W = 16;
  localparam int STEP_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_ONE   = 3'd0,
    REG_WEIGHT_TWO   = 3'd1,
    REG_WEIGHT_THREE = 3'd2,
    REG_WEIGHT_FOUR  = 3'd3,
    REG_TOTAL_DEGREE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_LOAD_W
  } idx_op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IDX_MORE,
    COND_WSEL_MORE,
    COND_MASK_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [STEP_W-1:0] {
    ST_WAIT,
    ST_CLEAR,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_NEXTW,
    ST_LREAD,
    ST_LACC,
    ST_OUT,
    ST_DONE
  } step_e;

  typedef struct packed {
    logic    in_ready;
    logic    init;
    idx_op_e idx_op;
    logic    clr_wr;
    logic    add_wr;
    logic    wsel_inc;
    logic    lk_rd;
    logic    lk_acc;
    logic    out_load;
    cond_e   cond;
    step_e   target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic idx_last;
    logic wsel_last;
    logic mask_last;
    logic out_busy;
  } stat_t;

  // control store: one word per step
  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '0;
    unique case (s)
      ST_WAIT: begin
        c.in_ready = 1'b1;
        c.init     = 1'b1;
        c.idx_op   = IDX_ZERO;
        c.cond     = COND_NO_INPUT;
        c.target   = ST_WAIT;
      end
      ST_CLEAR: begin
        c.clr_wr = 1'b1;
        c.idx_op = IDX_INC;
        c.cond   = COND_IDX_MORE;
        c.target = ST_CLEAR;
      end
      ST_SETUP: begin
        c.idx_op = IDX_LOAD_W;
        c.cond   = COND_NEVER;
      end
      ST_READ: begin
        c.cond = COND_NEVER;
      end
      ST_WRITE: begin
        c.add_wr = 1'b1;
        c.idx_op = IDX_INC;
        c.cond   = COND_IDX_MORE;
        c.target = ST_READ;
      end
      ST_NEXTW: begin
        c.wsel_inc = 1'b1;
        c.cond     = COND_WSEL_MORE;
        c.target   = ST_SETUP;
      end
      ST_LREAD: begin
        c.lk_rd = 1'b1;
        c.cond  = COND_NEVER;
      end
      ST_LACC: begin
        c.lk_acc = 1'b1;
        c.cond   = COND_MASK_MORE;
        c.target = ST_LREAD;
      end
      ST_OUT: begin
        c.out_load = 1'b1;
        c.cond     = COND_OUT_BUSY;
        c.target   = ST_OUT;
      end
      ST_DONE: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_WAIT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- src/whc_ram.sv -----
// ----------------------------------------------------------------------------
// whc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module whc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- src/whc_seq.sv -----
// ----------------------------------------------------------------------------
// whc_seq
// Step counter and control store; picks the next step from the condition
// field of the current control word.
// ----------------------------------------------------------------------------
module whc_seq
  import whc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_e step_q, step_d;
  ctrl_t ctrl;
  logic  jump;

  assign ctrl = ucode(step_q);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !stat_i.in_valid;
      COND_IDX_MORE:  jump = !stat_i.idx_last;
      COND_WSEL_MORE: jump = !stat_i.wsel_last;
      COND_MASK_MORE: jump = !stat_i.mask_last;
      COND_OUT_BUSY:  jump = stat_i.out_busy;
      default:        jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_e'(step_q + STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

  // an accepted beat always starts the table clear
  a_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.in_ready && stat_i.in_valid) |=> (step_q == ST_CLEAR))
    else $error("accepted beat did not start the clear sweep");

  // the last lookup hands over to the output step
  a_last_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_LACC && stat_i.mask_last) |=> (step_q == ST_OUT))
    else $error("last lookup did not reach the output step");

endmodule

// ----- src/whc_datapath.sv -----
// ----------------------------------------------------------------------------
// whc_datapath
// Configuration registers, coefficient table, index and subset counters,
// accumulator and output register, all steered by the control word.
// ----------------------------------------------------------------------------
module whc_datapath
  import whc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [N_W-1:0]        query_degree_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [CNT_W-1:0]      hilbert_value_o,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o
);

  logic [W_W-1:0]    weight_q [NUM_W];
  logic [D_W-1:0]    degree_q;
  logic [W_W-1:0]    weff [NUM_W];
  logic [W_W-1:0]    weff_sel;

  logic [N_W-1:0]    n_q;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [WSEL_W-1:0] wsel_q, wsel_d;
  logic [NUM_W-1:0]  mask_q, mask_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  logic              hit_q, odd_q;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_data_q;

  logic [WSUM_W-1:0] wsum;
  logic [K_W-1:0]    k;
  logic [KD_W-1:0]   kd;
  logic [ARG_W-1:0]  arg;
  logic              hit;
  logic              out_busy;
  logic              out_take;

  logic              we;
  logic [CNT_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [CNT_W-1:0]  rdata_a, rdata_b;
  logic [CNT_W-1:0]  term;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_W; i++) begin
        weight_q[i] <= W_W'(1);
      end
      degree_q <= D_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WEIGHT_ONE:   weight_q[0] <= cfg_data_i[W_W-1:0];
        REG_WEIGHT_TWO:   weight_q[1] <= cfg_data_i[W_W-1:0];
        REG_WEIGHT_THREE: weight_q[2] <= cfg_data_i[W_W-1:0];
        REG_WEIGHT_FOUR:  weight_q[3] <= cfg_data_i[W_W-1:0];
        REG_TOTAL_DEGREE: degree_q    <= cfg_data_i[D_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero weight acts as weight one
  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      weff[i] = (weight_q[i] == '0) ? W_W'(1) : weight_q[i];
    end
  end

  assign weff_sel = weff[wsel_q];

  // shifted argument of the current subset
  always_comb begin
    wsum = '0;
    k    = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (mask_q[i]) begin
        wsum = wsum + WSUM_W'(weff[i]);
        k    = k + K_W'(1);
      end
    end
  end

  assign kd  = KD_W'(k) * KD_W'(degree_q);
  assign arg = ARG_W'($signed(n_q)) + ARG_W'(wsum) - ARG_W'(kd);
  assign hit = !arg[ARG_W-1] && (arg[ARG_W-2:0] <= (ARG_W-1)'(MAX_ARG));

  // table ports
  assign we      = ctrl_i.clr_wr || ctrl_i.add_wr;
  assign wdata   = ctrl_i.clr_wr ? CNT_W'(idx_q == '0) : rdata_a + rdata_b;
  assign raddr_a = ctrl_i.lk_rd ? (hit ? arg[ADDR_W-1:0] : '0) : idx_q;
  assign raddr_b = idx_q - ADDR_W'(weff_sel);

  whc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (idx_q),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    unique case (ctrl_i.idx_op)
      IDX_HOLD:   idx_d = idx_q;
      IDX_ZERO:   idx_d = '0;
      IDX_INC:    idx_d = idx_q + ADDR_W'(1);
      IDX_LOAD_W: idx_d = ADDR_W'(weff_sel);
      default:    idx_d = idx_q;
    endcase
  end

  assign term = hit_q ? rdata_a : '0;

  always_comb begin
    wsel_d = wsel_q;
    mask_d = mask_q;
    acc_d  = acc_q;
    if (ctrl_i.init) begin
      wsel_d = '0;
      mask_d = '0;
      acc_d  = '0;
    end
    if (ctrl_i.wsel_inc) begin
      wsel_d = wsel_q + WSEL_W'(1);
    end
    if (ctrl_i.lk_acc) begin
      mask_d = mask_q + NUM_W'(1);
      acc_d  = odd_q ? acc_q - term : acc_q + term;
    end
  end

  // output register frees the sequencer once the result is parked
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_take = ctrl_i.out_load && !out_busy;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      wsel_q      <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      wsel_q      <= wsel_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.in_ready && in_valid_i) begin
      n_q <= query_degree_i;
    end
    if (ctrl_i.lk_rd) begin
      hit_q <= hit;
      odd_q <= ^mask_q;
    end
    if (out_take) begin
      out_data_q <= acc_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hilbert_value_o = out_data_q;

  assign stat_o.in_valid  = in_valid_i;
  assign stat_o.idx_last  = (idx_q == ADDR_W'(MAX_ARG));
  assign stat_o.wsel_last = (wsel_q == '1);
  assign stat_o.mask_last = (mask_q == '1);
  assign stat_o.out_busy  = out_busy;

  // a finished sweep leaves the index one past the last entry
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= ADDR_W'(TBL_DEPTH))
    else $error("table index beyond last entry");

  // an update pass never reaches below its own weight
  a_pass_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.add_wr |-> (idx_q >= ADDR_W'(weff_sel)))
    else $error("update pass index below weight");

  a_lookup_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.lk_acc |-> $past(ctrl_i.lk_rd))
    else $error("accumulate without a preceding lookup read");

endmodule

// ----- src/weighted_jacobian_hilbert_count_unit.sv -----
// ----------------------------------------------------------------------------
// weighted_jacobian_hilbert_count_unit
// Hilbert function of a weighted complete intersection in four variables.
// ----------------------------------------------------------------------------
// from the accepted beat to tvalid: table clear, then a read step and a write
//   step per entry in each of the four weight passes over the single
//   coefficient ram, then 16 lookups of a read step and an accumulate step,
//   then the output step, which waits while the output register is still full.
// one query at a time: no new beat before the last query is through, but the
//   next beat is taken while the result still waits in the output register.
// reset: weights 1, total degree 4, sequencer idle; table rebuilt per query.
module weighted_jacobian_hilbert_count_unit
  import whc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // [10:0] query_degree, rest zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CNT_W-1:0]      m_axis_tdata   // [31:0] hilbert_value
);

  ctrl_t ctrl;
  stat_t stat;

  whc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  whc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .query_degree_i  (s_axis_tdata[N_W-1:0]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .hilbert_value_o (m_axis_tdata),
    .ctrl_i          (ctrl),
    .stat_o          (stat)
  );

  assign s_axis_tready = ctrl.in_ready;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted Hilbert function unit. A directed table
// covers reset values, extreme weights and degrees, zero weights, zero degree,
// ignored register indexes and the query extremes. Random query phases follow,
// each under a fresh register setting. Every result beat is compared with a
// software copy of the inclusion-exclusion count, with random idling on both
// streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb
  import whc_pkg::*;
;

  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int TAIL_CYCLES  = 12_000;
  localparam int HOLD_AT      = 30;
  localparam int HOLD_CYCLES  = 30_000;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 18;
  localparam int NUM_ROWS     = 30;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam bit ROW_QUERY = 1'b0;
  localparam bit ROW_WRITE = 1'b1;

  typedef struct packed {
    bit                     kind;
    logic [CFG_IDX_W-1:0]   sel;
    logic [CFG_DATA_W-1:0]  data;
    logic signed [N_W-1:0]  query;
    bit                     pinned;
    logic [CNT_W-1:0]       pinned_value;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;   // [10:0] query_degree, rest zero
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [CNT_W-1:0]      m_axis_tdata;   // [31:0] hilbert_value

  logic [W_W-1:0]        weight_shadow [NUM_W];
  logic [D_W-1:0]        degree_shadow;
  logic [CNT_W-1:0]      hilbert_expected [$];
  stim_row_t             directed_rows [NUM_ROWS];
  int                    fault_count  = 0;
  int                    results_seen = 0;
  int                    cycle_count  = 0;

  weighted_jacobian_hilbert_count_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weighted_jacobian_hilbert_count_unit verification failed");
      $finish;
    end
  end

  // monomial counts of prod 1/(1 - t^w), then the signed sum over subsets
  function automatic logic [CNT_W-1:0] hilbert_predict(input logic signed [N_W-1:0] q);
    logic [CNT_W-1:0] monomials [TBL_DEPTH];
    int               wt [NUM_W];
    int               arg;
    int               k;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] acc;
    for (int i = 0; i < NUM_W; i++) begin
      wt[i] = (weight_shadow[i] == '0) ? 1 : int'(weight_shadow[i]);
    end
    for (int m = 0; m < TBL_DEPTH; m++) begin
      monomials[m] = '0;
    end
    monomials[0] = 1;
    for (int i = 0; i < NUM_W; i++) begin
      for (int m = wt[i]; m < TBL_DEPTH; m++) begin
        monomials[m] = monomials[m] + monomials[m - wt[i]];
      end
    end
    acc = '0;
    for (int mask = 0; mask < (1 << NUM_W); mask++) begin
      arg = q;
      k   = 0;
      for (int i = 0; i < NUM_W; i++) begin
        if (mask[i]) begin
          k++;
          arg += wt[i];
        end
      end
      arg -= k * int'(degree_shadow);
      c = (arg < 0 || arg > MAX_ARG) ? '0 : monomials[arg];
      if (k % 2 == 1) begin
        acc = acc - c;
      end else begin
        acc = acc + c;
      end
    end
    return acc;
  endfunction

  function automatic int draw_gap(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [N_W-1:0] draw_query();
    int               raw;
    logic [N_W-1:0]   q;
    case ($urandom_range(0, 9))
      0: begin
        raw = $urandom;
        q   = raw[N_W-1:0];
      end
      1: begin
        case ($urandom_range(0, 3))
          0:       q = 11'h400;
          1:       q = 11'h3FF;
          2:       q = '1;
          default: q = '0;
        endcase
      end
      default: begin
        // mostly where the shifted arguments land inside the count range
        raw = int'($urandom_range(0, 1283)) - 260;
        q   = raw[N_W-1:0];
      end
    endcase
    return q;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (sel)
      REG_WEIGHT_ONE:   weight_shadow[0] = data[W_W-1:0];
      REG_WEIGHT_TWO:   weight_shadow[1] = data[W_W-1:0];
      REG_WEIGHT_THREE: weight_shadow[2] = data[W_W-1:0];
      REG_WEIGHT_FOUR:  weight_shadow[3] = data[W_W-1:0];
      REG_TOTAL_DEGREE: degree_shadow    = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic offer(input logic signed [N_W-1:0] q, input bit pinned,
                       input logic [CNT_W-1:0] pinned_value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-N_W){1'b0}}, q};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hilbert_expected.push_back(pinned ? pinned_value : hilbert_predict(q));
  endtask

  // stop offering and let every outstanding result come back
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (hilbert_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_setup(input int phase);
    case (phase)
      1: begin
        write_reg(REG_WEIGHT_ONE, 8'h01);
        write_reg(REG_WEIGHT_TWO, 8'h01);
        write_reg(REG_WEIGHT_THREE, 8'h01);
        write_reg(REG_WEIGHT_FOUR, 8'h01);
        write_reg(REG_TOTAL_DEGREE, 8'h01);
      end
      2: begin
        write_reg(REG_WEIGHT_ONE, 8'h3F);
        write_reg(REG_WEIGHT_TWO, 8'h3F);
        write_reg(REG_WEIGHT_THREE, 8'h3F);
        write_reg(REG_WEIGHT_FOUR, 8'h3F);
        write_reg(REG_TOTAL_DEGREE, 8'h00);
      end
      default: begin
        write_reg(REG_WEIGHT_ONE, 8'($urandom_range(0, 255)));
        write_reg(REG_WEIGHT_TWO, 8'($urandom_range(0, 255)));
        write_reg(REG_WEIGHT_THREE, 8'($urandom_range(0, 255)));
        write_reg(REG_WEIGHT_FOUR, 8'($urandom_range(0, 255)));
        write_reg(REG_TOTAL_DEGREE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0) begin
          write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                    8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_WEIGHT_ONE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    for (int i = 0; i < NUM_W; i++) begin
      weight_shadow[i] = 6'd1;
    end
    degree_shadow = 8'd4;

    // all weights one, degree four: counts are binomials, the sum is easy by hand
    directed_rows = '{
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd0,    1'b1, 32'd1},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd1,    1'b1, 32'd4},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd2,    1'b1, 32'd10},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd3,    1'b1, 32'd16},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'h7FF,   1'b1, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'h400,   1'b1, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd1023, 1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd100,  1'b0, 32'd0},
      // upper data bits must be dropped on the weight registers
      '{ROW_WRITE, REG_WEIGHT_ONE,   8'hFF, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_WEIGHT_TWO,   8'hFF, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_WEIGHT_THREE, 8'hFF, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_WEIGHT_FOUR,  8'hFF, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_TOTAL_DEGREE, 8'hFF, 11'sd0,    1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd1023, 1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'h400,   1'b1, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd252,  1'b0, 32'd0},
      // zero weights act as one, zero degree leaves the shifts positive
      '{ROW_WRITE, REG_WEIGHT_ONE,   8'h00, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_WEIGHT_TWO,   8'h40, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_WEIGHT_THREE, 8'h02, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_WEIGHT_FOUR,  8'h03, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_TOTAL_DEGREE, 8'h00, 11'sd0,    1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd0,    1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd50,   1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, -11'sd3,   1'b0, 32'd0},
      '{ROW_WRITE, REG_SPARE_LO,     8'hAA, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_SPARE_HI,     8'h55, 11'sd0,    1'b0, 32'd0},
      '{ROW_WRITE, REG_TOTAL_DEGREE, 8'h01, 11'sd0,    1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd10,   1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, 11'sd1023, 1'b0, 32'd0},
      '{ROW_QUERY, REG_WEIGHT_ONE,   8'h00, -11'sd7,   1'b0, 32'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        quiesce();
        write_reg(directed_rows[i].sel, directed_rows[i].data);
      end else begin
        pause(draw_gap(1'b0));
        offer(directed_rows[i].query, directed_rows[i].pinned, directed_rows[i].pinned_value);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      random_setup(p);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pause(draw_gap(p % 3 == 1));
        offer(draw_query(), 1'b0, '0);
      end
    end

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("weighted_jacobian_hilbert_count_unit verification clean");
    end else begin
      $display("weighted_jacobian_hilbert_count_unit verification failed");
    end
    $finish;
  end

  initial begin : result_side
    int               stall;
    bit               held;
    logic [CNT_W-1:0] want;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen == HOLD_AT) begin
        // long hold-off so the unit fills up and backs up its input
        held = 1'b1;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
      end else begin
        stall = draw_gap((results_seen / 16) % 3 == 2);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      results_seen++;
      if (hilbert_expected.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result beat, expected none actual 0x%08h", $time,
                 m_axis_tdata);
      end else begin
        want = hilbert_expected.pop_front();
        if (m_axis_tdata !== want) begin
          fault_count++;
          $display("%0t: hilbert_value mismatch, expected %0d (0x%08h) actual %0d (0x%08h)",
                   $time, $signed(want), want, $signed(m_axis_tdata), m_axis_tdata);
        end
      end
    end
  end

endmodule

// ----- files.f -----
src/whc_pkg.sv
src/whc_ram.sv
src/whc_seq.sv
src/whc_datapath.sv
src/weighted_jacobian_hilbert_count_unit.sv
tb/tb.sv
